>>> hdl/lz4_variant_token_fixup_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the LZ4 variant token fixup.
// Each macro uses the clk and arst_n names of the module that expands it.
// ---------------------------------------------------------------------------
`ifndef LZ4_VARIANT_TOKEN_FIXUP_DEFINES_SVH
`define LZ4_VARIANT_TOKEN_FIXUP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define LVTF_ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// A condition that, when it holds, must be followed by another in the next cycle.
`define LVTF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// A condition that, when it holds, implies another in the same cycle.
`define LVTF_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hdl/lz4vtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lz4vtf_pkg
// Types and constants shared by the LZ4 variant token fixup modules.
// ---------------------------------------------------------------------------
package lz4vtf_pkg;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_TOKEN     = 3'd0,
		PH_LIT_EXT   = 3'd1,
		PH_LITERAL   = 3'd2,
		PH_OFFSET0   = 3'd3,
		PH_OFFSET1   = 3'd4,
		PH_MATCH_EXT = 3'd5,
		PH_PASS      = 3'd6
	} phase_t;

	// Length code that announces extension bytes.
	localparam logic [3:0] LEN_EXT_CODE = 4'hF;
	// Extension byte value that means another extension byte follows.
	localparam logic [7:0] EXT_MORE     = 8'hFF;
	// Minimum match length added to every match code.
	localparam int unsigned MATCH_MIN   = 4;

	// Output queue geometry.
	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QCNT_W      = 3;

	// One output byte with its end marker.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	// Up to two output bytes produced by one input byte.
	typedef struct packed {
		logic [1:0] num;
		item_t      first;
		item_t      second;
	} res_t;

endpackage
`default_nettype wire

>>> hdl/lz4vtf_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lz4vtf_parser
// Sequence parser: tracks the phase of the block, sums lengths, swaps token
// nibbles and offset bytes, and yields zero, one or two bytes per input byte.
// ---------------------------------------------------------------------------
module lz4vtf_parser
	import lz4vtf_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data,
	input  wire logic        last,
	input  wire logic [30:0] limit,
	output res_t             res
);

	localparam int unsigned CW = COUNT_WIDTH;

	phase_t           phase_q, phase_d;
	logic [7:0]       held_q, held_d;
	logic [CW-1:0]    run_q, run_d;
	logic [3:0]       match_q, match_d;
	logic [CW-1:0]    cnt_q, cnt_d;

	logic [CW:0]      ext_sum;
	logic [CW-1:0]    run_ext;
	logic [CW-1:0]    lk_run;
	logic [CW:0]      lk_sum;
	logic [CW-1:0]    lk_cnt;
	phase_t           lk_phase;
	logic [CW-1:0]    m_run;
	logic [CW+1:0]    m_sum;
	logic [CW-1:0]    m_cnt;
	logic [CW-1:0]    run_dec;

	// Saturating length sums.
	always_comb begin
		ext_sum = {1'b0, run_q} + (CW+1)'(data);
		run_ext = ext_sum[CW] ? '1 : ext_sum[CW-1:0];

		// Literal length is final: add it to the output count and pick the next phase.
		lk_run = (phase_q == PH_TOKEN) ? CW'(data[3:0]) : run_ext;
		lk_sum = {1'b0, cnt_q} + {1'b0, lk_run};
		lk_cnt = lk_sum[CW] ? '1 : lk_sum[CW-1:0];
		if (33'(lk_cnt) >= 33'(limit)) begin
			lk_phase = PH_PASS;
		end else if (lk_run != '0) begin
			lk_phase = PH_LITERAL;
		end else begin
			lk_phase = PH_OFFSET0;
		end

		// Match length is final: add it plus the minimum match to the output count.
		m_run = (phase_q == PH_OFFSET1) ? CW'(match_q) : run_ext;
		m_sum = (CW+2)'(cnt_q) + (CW+2)'(m_run) + (CW+2)'(MATCH_MIN);
		m_cnt = (m_sum[CW+1:CW] != 2'b00) ? '1 : m_sum[CW-1:0];

		run_dec = (run_q != '0) ? run_q - CW'(1) : run_q;
	end

	// Next state and results.
	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		run_d   = run_q;
		match_d = match_q;
		cnt_d   = cnt_q;

		res.num         = 2'd1;
		res.first.data  = data;
		res.first.last  = last;
		res.second.data = held_q;
		res.second.last = last;

		unique case (phase_q)
			PH_TOKEN: begin
				res.first.data = {data[3:0], data[7:4]};
				match_d        = data[7:4];
				run_d          = CW'(data[3:0]);
				if (data[3:0] == LEN_EXT_CODE) begin
					phase_d = PH_LIT_EXT;
				end else begin
					cnt_d   = lk_cnt;
					phase_d = lk_phase;
				end
			end
			PH_LIT_EXT: begin
				run_d = run_ext;
				if (data != EXT_MORE) begin
					cnt_d   = lk_cnt;
					phase_d = lk_phase;
				end
			end
			PH_LITERAL: begin
				run_d = run_dec;
				if (run_dec == '0) begin
					phase_d = PH_OFFSET0;
				end
			end
			PH_OFFSET0: begin
				// A lone offset byte at the end of the block passes unchanged.
				if (!last) begin
					held_d  = data;
					phase_d = PH_OFFSET1;
					res.num = 2'd0;
				end
			end
			PH_OFFSET1: begin
				res.num        = 2'd2;
				res.first.last = 1'b0;
				run_d          = CW'(match_q);
				if (match_q == LEN_EXT_CODE) begin
					phase_d = PH_MATCH_EXT;
				end else begin
					cnt_d   = m_cnt;
					phase_d = PH_TOKEN;
				end
			end
			PH_MATCH_EXT: begin
				run_d = run_ext;
				if (data != EXT_MORE) begin
					cnt_d   = m_cnt;
					phase_d = PH_TOKEN;
				end
			end
			PH_PASS: begin
			end
			default: begin
				phase_d = PH_TOKEN;
			end
		endcase

		// The end of the block returns the parser to its starting state.
		if (last) begin
			phase_d = PH_TOKEN;
			held_d  = '0;
			run_d   = '0;
			match_d = '0;
			cnt_d   = '0;
		end

		if (!step) begin
			res.num = 2'd0;
		end
	end

	// State registers, updated only when a byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN;
			held_q  <= '0;
			run_q   <= '0;
			match_q <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			run_q   <= run_d;
			match_q <= match_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/lz4vtf_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lz4vtf_outq
// Four-entry shifting output queue: takes up to two bytes per cycle while it has room, and
// presents the oldest one on the output channel.
// ---------------------------------------------------------------------------
module lz4vtf_outq
	import lz4vtf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire res_t       push,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	`include "lz4_variant_token_fixup_defines.svh"

	item_t               q_q [QDEPTH];
	item_t               q_d [QDEPTH];
	logic [QCNT_W-1:0]   count_q, count_d;
	logic [QCNT_W-1:0]   base;
	logic                pop;
	logic                pop_only;
	logic [QCNT_W-1:0]   count_dec;

	// The head entry is always the one on the output.
	assign out_valid = (count_q != '0);
	assign out_byte  = q_q[0].data;
	assign out_last  = q_q[0].last;
	assign pop       = out_valid && out_ready;
	// Room for two new bytes whatever the output side does.
	assign room      = (count_q <= QCNT_W'(QDEPTH - 2));

	// A transfer out with nothing arriving, and the count it should leave behind.
	assign pop_only  = pop && (push.num == 2'd0);
	assign count_dec = count_q - QCNT_W'(1);

	// Shift on a transfer out, then place the new bytes behind the survivors.
	always_comb begin
		base    = count_q - QCNT_W'(pop);
		count_d = base + QCNT_W'(push.num);
		for (int i = 0; i < QDEPTH; i++) begin
			if (pop && (i < QDEPTH - 1)) begin
				q_d[i] = q_q[i+1];
			end else begin
				q_d[i] = q_q[i];
			end
			if ((push.num != 2'd0) && (base == QCNT_W'(i))) begin
				q_d[i] = push.first;
			end
			if ((push.num == 2'd2) && (base + QCNT_W'(1) == QCNT_W'(i))) begin
				q_d[i] = push.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			q_q[i] <= q_d[i];
		end
	end

	`LVTF_ASSERT_ALWAYS(a_no_overflow, count_q <= QCNT_W'(QDEPTH), "output queue overflow")
	`LVTF_ASSERT_IMPLY(a_push_room, push.num != 2'd0, room, "push without room")
	`LVTF_ASSERT_NEXT(a_pop_only, pop_only, count_q == $past(count_dec), "count not decremented")

endmodule
`default_nettype wire

>>> hdl/lz4_variant_token_fixup.sv
`timescale 1ns / 1ps
`default_nettype none
// Data path: an accepted byte is registered in the input register, then parsed, and its results
// are written into the output queue, whose head entry is offered on the output channel.
// Throughput: one input byte per cycle while the output queue has room; the four-entry
// output queue absorbs the two bytes emitted for an offset pair.
// Reset: arst_n clears the parser state, the queue count and the output limit at once.
// ---------------------------------------------------------------------------
// lz4_variant_token_fixup
// Rewrites a variant LZ4 block into a standard LZ4 block, one byte at a time.
// ---------------------------------------------------------------------------
module lz4_variant_token_fixup
	import lz4vtf_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [30:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic [30:0] output_limit_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        room;
	logic        step;
	res_t        res;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q <= '0;
		end else if (cfg_wr_en) begin
			output_limit_q <= cfg_wr_data;
		end
	end

	// Input register: refilled in the same cycle that its byte is parsed.
	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Parser.
	lz4vtf_parser #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (data_s1),
		.last   (last_s1),
		.limit  (output_limit_q),
		.res    (res)
	);

	// Output queue.
	lz4vtf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule
`default_nettype wire
